// ----- sv/dlrs_pkg.sv -----
// shared types and constants for the decimal lsd radix sorter
// no dependencies
package dlrs_pkg;

  localparam int unsigned Radix     = 10;
  localparam int unsigned MaxPasses = 20;
  localparam int unsigned DigitW    = 4;

  typedef enum logic [6:0] {
    StLoad    = 7'b0000001,
    StCheck   = 7'b0000010,
    StClear   = 7'b0000100,
    StCount   = 7'b0001000,
    StPrefix  = 7'b0010000,
    StScatter = 7'b0100000,
    StEmit    = 7'b1000000
  } state_e;

endpackage

// ----- sv/dlrs_digit.sv -----
// divides a key by ten: quotient and low decimal digit, no divider
// depends on dlrs_pkg
module dlrs_digit
  import dlrs_pkg::*;
#(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] quot_i,
  output logic [KEY_BITS-1:0] quot_o,
  output logic [DigitW-1:0]   digit_o
);
  // shift-add estimate of n * 0.8, scaled by 1/8, low by at most one
  logic [KEY_BITS-1:0] est;
  logic [KEY_BITS-1:0] back;
  logic [KEY_BITS-1:0] rem;
  always_comb begin
    est = (quot_i >> 1) + (quot_i >> 2);
    for (int s = 4; s < KEY_BITS; s = s * 2) begin
      est = est + (est >> s);
    end
    est  = est >> 3;
    back = (est << 3) + (est << 1);
    rem  = quot_i - back;
    // remainder of ten or more means the estimate was one short
    if (rem > KEY_BITS'(9)) begin
      quot_o  = est + 1'b1;
      digit_o = DigitW'(rem - KEY_BITS'(10));
    end else begin
      quot_o  = est;
      digit_o = DigitW'(rem);
    end
  end
endmodule

// ----- sv/decimal_lsd_radix_sort.sv -----
// decimal lsd radix sorter: load one word per cycle until tlast, then sort and emit
// passes = decimal digits of largest key; pass p is check, clear of the ten counters, count,
// prefix over the ten counters and scatter; each record is stepped down one digit per cycle
// banks swap after scatter, so no copy-back; emit reads the next word only after the last is taken
// a set of n words is sorted and emitted before the next set is loaded, one set at a time
// reset (rst_ni low, async) clears count, largest key, drop flag, counters and state
module decimal_lsd_radix_sort
  import dlrs_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: record key, record tag
  input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: out_key, out_tag
  output logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // tuser: overflowed
  output logic m_axis_tuser
);
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned RW = KEY_BITS + TAG_BITS;
  localparam int unsigned DW = ((RW + 7) / 8) * 8;
  localparam int unsigned PW = $clog2(MaxPasses + 1);

  // two record banks; the active bank flips after each scatter
  logic [RW-1:0] bank0 [MAX_RECORDS];
  logic [RW-1:0] bank1 [MAX_RECORDS];
  logic [CW-1:0] cnt_q [Radix];

  state_e state_q, state_d;
  logic sel_q;
  logic [CW-1:0] n_q, idx_q;
  // largest key, divided by ten at each pass check that starts a pass
  logic [KEY_BITS-1:0] max_q;
  logic drop_q;
  logic [PW-1:0] pass_q;
  logic [3:0] dptr_q;
  logic [CW-1:0] run_q;

  // read port of active bank, registered; request is held back a register stage for a new address
  logic [RW-1:0] rd_q;
  logic rd_req_q, rd_vld_q;
  logic [AW-1:0] rd_addr;

  // digit stepper: key divided by ten once per cycle, pass_q times
  logic [KEY_BITS-1:0] div_quo_q, dig_in, quo_next;
  logic [PW-1:0] div_cnt_q;
  logic div_busy_q, div_done_q;
  logic [DigitW-1:0] digit;
  logic out_pend_q;
  logic [RW-1:0] out_q;
  logic out_last_q;

  // the pass check borrows the divider for the largest key
  assign dig_in = (state_q == StCheck) ? max_q : div_quo_q;

  dlrs_digit #(.KEY_BITS(KEY_BITS)) u_digit (
    .quot_i(dig_in), .quot_o(quo_next), .digit_o(digit)
  );

  assign s_axis_tready = (state_q == StLoad);
  wire in_acc = s_axis_tvalid && s_axis_tready;
  wire [KEY_BITS-1:0] in_key = s_axis_tdata[KEY_BITS-1:0];
  wire [RW-1:0] in_rec = s_axis_tdata[RW-1:0];
  wire full = (n_q == CW'(MAX_RECORDS));
  wire m_acc = m_axis_tvalid && m_axis_tready;

  assign rd_addr = idx_q[AW-1:0];
  assign m_axis_tvalid = out_pend_q;
  assign m_axis_tdata = DW'(out_q);
  assign m_axis_tlast = out_last_q;
  assign m_axis_tuser = drop_q;

  // memory reads
  always_ff @(posedge clk_i) begin
    rd_q <= sel_q ? bank1[rd_addr] : bank0[rd_addr];
  end

  // scatter address: running start of digit
  logic [CW-1:0] pos;
  assign pos = cnt_q[digit];
  logic wr_sc;
  assign wr_sc = (state_q == StScatter) && div_done_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      if (sel_q) bank1[n_q[AW-1:0]] <= in_rec;
      else       bank0[n_q[AW-1:0]] <= in_rec;
    end
    if (wr_sc) begin
      if (sel_q) bank0[pos[AW-1:0]] <= rd_q;
      else       bank1[pos[AW-1:0]] <= rd_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad:    if (in_acc && s_axis_tlast) state_d = StCheck;
      StCheck:   state_d = (pass_q != PW'(MaxPasses) && max_q != '0 &&
                            n_q != '0) ? StClear : (n_q != '0 ? StEmit : StLoad);
      StClear:   if (dptr_q == 4'(Radix - 1)) state_d = StCount;
      StCount:   if (div_done_q && idx_q == n_q - 1'b1) state_d = StPrefix;
      StPrefix:  if (dptr_q == 4'(Radix - 1)) state_d = StScatter;
      StScatter: if (div_done_q && idx_q == n_q - 1'b1) state_d = StCheck;
      StEmit:    if (m_acc && out_last_q) state_d = StLoad;
      default:   state_d = StLoad;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; sel_q <= 1'b0; n_q <= '0; max_q <= '0; drop_q <= 1'b0;
      pass_q <= '0; dptr_q <= '0; idx_q <= '0;
      rd_req_q <= 1'b0; rd_vld_q <= 1'b0;
      div_busy_q <= 1'b0; div_done_q <= 1'b0; div_cnt_q <= '0; div_quo_q <= '0;
      out_pend_q <= 1'b0; out_last_q <= 1'b0; out_q <= '0; run_q <= '0;
      for (int unsigned d = 0; d < Radix; d++) cnt_q[d] <= '0;
    end else begin
      state_q <= state_d;
      div_done_q <= 1'b0;
      rd_req_q <= 1'b0;
      rd_vld_q <= rd_req_q;
      unique case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (full) drop_q <= 1'b1;
            else begin
              n_q <= n_q + 1'b1;
              if (in_key > max_q) max_q <= in_key;
            end
          end
          pass_q <= '0; idx_q <= '0;
        end
        StCheck: begin
          dptr_q <= '0; idx_q <= '0;
          if (state_d == StClear) max_q <= quo_next;
        end
        StClear: begin
          cnt_q[dptr_q] <= '0;
          dptr_q <= (dptr_q == 4'(Radix - 1)) ? '0 : dptr_q + 1'b1;
          if (dptr_q == 4'(Radix - 1)) rd_vld_q <= 1'b1;
        end
        StCount, StScatter: begin
          if (rd_vld_q) begin
            div_busy_q <= 1'b1; div_cnt_q <= pass_q;
            div_quo_q <= rd_q[KEY_BITS-1:0];
          end else if (div_busy_q) begin
            // drop one low decimal digit per cycle until the pass digit is lowest
            if (div_cnt_q == '0) begin
              div_busy_q <= 1'b0; div_done_q <= 1'b1;
            end else begin
              div_quo_q <= quo_next;
              div_cnt_q <= div_cnt_q - 1'b1;
            end
          end else if (div_done_q) begin
            cnt_q[digit] <= cnt_q[digit] + 1'b1;
            if (idx_q == n_q - 1'b1) begin
              idx_q <= '0;
              if (state_q == StScatter) begin
                sel_q <= ~sel_q; pass_q <= pass_q + 1'b1;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
              rd_req_q <= 1'b1;
            end
          end
        end
        StPrefix: begin
          cnt_q[dptr_q] <= run_q;
          run_q <= (dptr_q == 4'(Radix - 1)) ? '0 : run_q + cnt_q[dptr_q];
          dptr_q <= (dptr_q == 4'(Radix - 1)) ? '0 : dptr_q + 1'b1;
          if (dptr_q == 4'(Radix - 1)) rd_vld_q <= 1'b1;
        end
        StEmit: begin
          // idx_q counts read requests; one read in flight feeds output reg
          if (!out_pend_q && !rd_vld_q && idx_q == '0 && !out_last_q) begin
            rd_vld_q <= 1'b1; idx_q <= idx_q + 1'b1;
          end else if (rd_vld_q) begin
            out_pend_q <= 1'b1; out_q <= rd_q;
            out_last_q <= (idx_q == n_q);
          end else if (m_acc) begin
            out_pend_q <= 1'b0;
            if (out_last_q) begin
              out_last_q <= 1'b0; n_q <= '0; max_q <= '0; drop_q <= 1'b0;
              idx_q <= '0;
            end else begin
              rd_vld_q <= 1'b1; idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // assertions
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !s_axis_tready) else $error("ready outside load");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == StEmit)) else $error("output outside emit");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_RECORDS)) else $error("record count beyond capacity");
endmodule
